/* hdl/nce_pkg.sv */
// Shared types and constants for the nonzero coordinate extractor.
package nce_pkg;

    localparam int DIMS       = 6;   // dimensions in the register map
    localparam int NUM_DIMS   = 6;   // innermost dimensions that count (1..6)
    localparam int COORD_BITS = 16;  // stored index width
    localparam int COUNT_BITS = 32;  // nonzero counter width

    localparam int VALUE_W    = 32;
    localparam int COORD_W    = 16;
    localparam int ORD_W      = 32;
    localparam int SIZE_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int KIND_W     = 3;

    // compare width wide enough for index + 1 against a size
    localparam int CMP_W = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;

    localparam int QUEUE_DEPTH = 4;  // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_BATCH   = 3'd0,
        REG_SIZE_DIM1    = 3'd1,
        REG_SIZE_DIM2    = 3'd2,
        REG_SIZE_CHANNEL = 3'd3,
        REG_SIZE_HEIGHT  = 3'd4,
        REG_SIZE_WIDTH   = 3'd5,
        REG_ELEMENT_KIND = 3'd6,
        REG_COORD_COUNT  = 3'd7
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_U8   = 3'd0,
        KIND_S8   = 3'd1,
        KIND_U16  = 3'd2,
        KIND_S16  = 3'd3,
        KIND_U32  = 3'd4,
        KIND_S32  = 3'd5,
        KIND_F32  = 3'd6,
        KIND_BOOL = 3'd7
    } elem_kind_t;

    typedef enum logic {
        REC_COORD = 1'b0,
        REC_COUNT = 1'b1
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t                   kind;
        logic [DIMS-1:0][COORD_W-1:0] coord;
        logic [ORD_W-1:0]            ordinal;
        logic                        last;
    } rec_t;

endpackage

/* hdl/nce_ifs.sv */
// Stream interfaces: tensor elements in, coordinate/count records out.
interface nce_in_if
    import nce_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface nce_out_if
    import nce_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               record_kind;
    logic [COORD_W-1:0] coord_0;
    logic [COORD_W-1:0] coord_1;
    logic [COORD_W-1:0] coord_2;
    logic [COORD_W-1:0] coord_3;
    logic [COORD_W-1:0] coord_4;
    logic [COORD_W-1:0] coord_5;
    logic [ORD_W-1:0]   ordinal;
    logic               last;

    modport source (output valid, output record_kind, output coord_0, output coord_1,
                    output coord_2, output coord_3, output coord_4, output coord_5,
                    output ordinal, output last, input ready);
    modport sink   (input valid, input record_kind, input coord_0, input coord_1,
                    input coord_2, input coord_3, input coord_4, input coord_5,
                    input ordinal, input last, output ready);
endinterface

/* hdl/nce_rec_queue.sv */
// Record queue: takes up to two records per cycle, hands out one beat per cycle while the sink is ready.
module nce_rec_queue
    import nce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_cnt,
    input  rec_t        push_a,
    input  rec_t        push_b,
    output logic        space_ok,
    nce_out_if.source   records
);

    rec_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;
    rec_t              head;

    assign pop      = records.valid && records.ready;
    assign space_ok = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign head     = mem_reg[rd_ptr_reg];

    assign count_next = count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_cnt);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign records.valid       = count_reg != '0;
    assign records.record_kind = head.kind;
    assign records.coord_0     = head.coord[0];
    assign records.coord_1     = head.coord[1];
    assign records.coord_2     = head.coord[2];
    assign records.coord_3     = head.coord[3];
    assign records.coord_4     = head.coord[4];
    assign records.coord_5     = head.coord[5];
    assign records.ordinal     = head.ordinal;
    assign records.last        = head.last;

endmodule

/* hdl/nonzero_coordinate_extractor.sv */
// Nonzero coordinate extractor: top level with index counters and nonzero count.
//
// Elements arrive one per beat in row-major order and one can be accepted every
// cycle while the queue has room. Each element is tested, its coordinate record
// built from the current index counters and the counters stepped in the same
// cycle; the records go into a four-entry queue. An element gives at most two
// records (coordinate, then count on the tensor's final element), so the input
// is ready while the queue has two free slots. With the output taking a beat per
// cycle the sustained rate is one element per cycle; the final element of a
// tensor with a nonzero last element pushes both records into the queue at once.
module nonzero_coordinate_extractor
    import nce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    nce_in_if.sink               elements,
    nce_out_if.source            records
);

    logic [SIZE_W-1:0]     size_reg [DIMS];
    elem_kind_t            kind_reg;
    logic [KIND_W-1:0]     ccount_reg;

    logic [COORD_BITS-1:0] idx_reg  [DIMS];
    logic [COORD_BITS-1:0] idx_next [DIMS];
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_inc;

    logic [DIMS-1:0]       at_end;
    logic                  final_elem;
    logic                  nonzero;
    logic                  accept;
    logic                  space_ok;
    logic [KIND_W-1:0]     cnt;
    logic [1:0]            push_cnt;
    rec_t                  coord_rec;
    rec_t                  count_rec;
    rec_t                  push_a;

    assign accept = elements.valid && elements.ready;
    assign elements.ready = space_ok;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                size_reg[d] <= SIZE_W'(1);
            end
            kind_reg   <= KIND_U8;
            ccount_reg <= KIND_W'(DIMS);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SIZE_BATCH, REG_SIZE_DIM1, REG_SIZE_DIM2,
                REG_SIZE_CHANNEL, REG_SIZE_HEIGHT, REG_SIZE_WIDTH:
                    size_reg[cfg_index] <= cfg_data[SIZE_W-1:0];
                REG_ELEMENT_KIND: kind_reg   <= elem_kind_t'(cfg_data[KIND_W-1:0]);
                REG_COORD_COUNT:  ccount_reg <= cfg_data[KIND_W-1:0];
            endcase
        end
    end

    // nonzero test, only the kind's width is examined (F32 ignores the sign bit)
    always_comb
    begin
        unique case (kind_reg)
            KIND_U8, KIND_S8, KIND_BOOL: nonzero = |elements.value[7:0];
            KIND_U16, KIND_S16:          nonzero = |elements.value[15:0];
            KIND_F32:                    nonzero = |elements.value[30:0];
            KIND_U32, KIND_S32:          nonzero = |elements.value;
        endcase
    end

    // end-of-dimension flags; size 0 acts as 1, unused outer dims have size 1
    always_comb
    begin
        logic [SIZE_W-1:0] eff;
        for (int d = 0; d < DIMS; d++)
        begin
            if (d < DIMS - NUM_DIMS || size_reg[d] == '0)
            begin
                eff = SIZE_W'(1);
            end
            else
            begin
                eff = size_reg[d];
            end
            at_end[d] = (CMP_W'(idx_reg[d]) + CMP_W'(1)) >= CMP_W'(eff);
        end
    end

    assign final_elem = &at_end;

    // cascaded increment, innermost first
    always_comb
    begin
        logic carry;
        carry = 1'b1;
        for (int d = DIMS - 1; d >= 0; d--)
        begin
            idx_next[d] = idx_reg[d];
            if (carry)
            begin
                if (at_end[d])
                begin
                    idx_next[d] = '0;
                end
                else
                begin
                    idx_next[d] = idx_reg[d] + COORD_BITS'(1);
                    carry       = 1'b0;
                end
            end
        end
        if (final_elem)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                idx_next[d] = '0;
            end
        end
    end

    assign total_inc = (total_reg != '1) ? total_reg + COUNT_BITS'(1) : total_reg;
    assign cnt = (ccount_reg > KIND_W'(DIMS)) ? KIND_W'(DIMS) : ccount_reg;

    // records, right-aligned innermost coordinates
    always_comb
    begin
        logic [KIND_W-1:0] sel;
        coord_rec.kind    = REC_COORD;
        coord_rec.ordinal = ORD_W'(total_reg);
        coord_rec.last    = 1'b0;
        for (int j = 0; j < DIMS; j++)
        begin
            sel = KIND_W'(DIMS) - cnt + KIND_W'(j);
            if (KIND_W'(j) < cnt)
            begin
                coord_rec.coord[j] = COORD_W'(idx_reg[sel]);
            end
            else
            begin
                coord_rec.coord[j] = '0;
            end
        end

        count_rec.kind    = REC_COUNT;
        count_rec.coord   = '0;
        count_rec.ordinal = ORD_W'(nonzero ? total_inc : total_reg);
        count_rec.last    = 1'b1;
    end

    assign push_a   = nonzero ? coord_rec : count_rec;
    assign push_cnt = accept ? ({1'b0, nonzero} + {1'b0, final_elem}) : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                idx_reg[d] <= '0;
            end
            total_reg <= '0;
        end
        else if (accept)
        begin
            idx_reg <= idx_next;
            if (final_elem)
            begin
                total_reg <= '0;
            end
            else if (nonzero)
            begin
                total_reg <= total_inc;
            end
        end
    end

    nce_rec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (count_rec),
        .space_ok (space_ok),
        .records  (records)
    );

    // counters restart after the final element of a tensor
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_elem |=> total_reg == '0 && idx_reg[DIMS-1] == '0)
        else $error("counters not cleared after final element");

    // count only grows inside a tensor
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !final_elem |=> total_reg >= $past(total_reg))
        else $error("nonzero count went backwards");

    // a count beat always carries the last flag and no coordinates
    a_count_rec: assert property (@(posedge clk) disable iff (!rst_n)
        records.valid && records.record_kind |->
            records.last && records.coord_5 == '0 && records.coord_0 == '0)
        else $error("malformed count record");

    // no element is taken without room for both of its records
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> space_ok)
        else $error("element accepted without queue room");

endmodule
